>>> rtl/tfds_pkg.sv
`default_nettype none
package tfds_pkg;

	localparam int TEMP_W    = 18;
	localparam int MASK_W    = 5;
	localparam int DUTY_W    = 7;
	localparam int LEVEL_W   = 2;
	localparam int FAN_COUNT = 5;

	localparam logic [MASK_W-1:0] MON_MASK = (FAN_COUNT >= MASK_W) ? {MASK_W{1'b1}} :
		MASK_W'((1 << FAN_COUNT) - 1);

	localparam logic [LEVEL_W-1:0] LVL_40  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_65  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_80  = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_100 = 2'd3;

	localparam logic [DUTY_W-1:0] DUTY_40  = 7'd40;
	localparam logic [DUTY_W-1:0] DUTY_65  = 7'd65;
	localparam logic [DUTY_W-1:0] DUTY_80  = 7'd80;
	localparam logic [DUTY_W-1:0] DUTY_100 = 7'd100;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               write;
		logic               fault;
	} step_t;

	function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
		logic [DUTY_W-1:0] d;
		case (lvl)
			LVL_40:  d = DUTY_40;
			LVL_65:  d = DUTY_65;
			LVL_80:  d = DUTY_80;
			default: d = DUTY_100;
		endcase
		return d;
	endfunction

	function automatic temp_t up_at(input logic f2b, input logic [LEVEL_W-1:0] lvl);
		temp_t t;
		case (lvl)
			LVL_40:  t = f2b ? temp_t'(47950) : temp_t'(40850);
			LVL_65:  t = f2b ? temp_t'(49650) : temp_t'(44850);
			LVL_80:  t = f2b ? temp_t'(54050) : temp_t'(47400);
			default: t = temp_t'(0);
		endcase
		return t;
	endfunction

	function automatic temp_t down_at(input logic f2b, input logic [LEVEL_W-1:0] lvl);
		temp_t t;
		case (lvl)
			LVL_65:  t = f2b ? temp_t'(42050) : temp_t'(35400);
			LVL_80:  t = f2b ? temp_t'(47050) : temp_t'(40400);
			LVL_100: t = f2b ? temp_t'(52050) : temp_t'(45400);
			default: t = temp_t'(0);
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tfds_if.sv
`default_nettype none
interface tfds_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [tfds_pkg::TEMP_W-1:0] temp_first;
	logic signed [tfds_pkg::TEMP_W-1:0] temp_second;
	logic [tfds_pkg::MASK_W-1:0]     fan_present_mask;
	logic [tfds_pkg::MASK_W-1:0]     fan_failed_mask;
	logic                            airflow_front_to_back;

	modport source(output valid, temp_first, temp_second, fan_present_mask,
		fan_failed_mask, airflow_front_to_back, input ready);
	modport sink(input valid, temp_first, temp_second, fan_present_mask,
		fan_failed_mask, airflow_front_to_back, output ready);
endinterface

interface tfds_out_if;
	logic                        valid;
	logic                        ready;
	logic [tfds_pkg::DUTY_W-1:0] duty_percent;
	logic                        write_duty;

	modport source(output valid, duty_percent, write_duty, input ready);
	modport sink(input valid, duty_percent, write_duty, output ready);
endinterface
`default_nettype wire

>>> rtl/tfds_step.sv
`default_nettype none
module tfds_step (
	input  wire logic [tfds_pkg::LEVEL_W-1:0]    level,
	input  wire logic signed [tfds_pkg::TEMP_W-1:0] temp_first,
	input  wire logic signed [tfds_pkg::TEMP_W-1:0] temp_second,
	input  wire logic [tfds_pkg::MASK_W-1:0]     fan_present_mask,
	input  wire logic [tfds_pkg::MASK_W-1:0]     fan_failed_mask,
	input  wire logic                            airflow_front_to_back,
	output tfds_pkg::step_t                      step
);

	logic signed [tfds_pkg::TEMP_W:0]   sum;
	logic signed [tfds_pkg::TEMP_W:0]   sum_adj;
	logic signed [tfds_pkg::TEMP_W-1:0] avg;
	logic                               fault;
	logic                               go_up;
	logic                               go_down;

	assign fault = ((fan_present_mask & tfds_pkg::MON_MASK) != tfds_pkg::MON_MASK) ||
		((fan_failed_mask & tfds_pkg::MON_MASK) != '0);

	// truncate toward zero
	assign sum     = {temp_first[tfds_pkg::TEMP_W-1], temp_first} +
		{temp_second[tfds_pkg::TEMP_W-1], temp_second};
	assign sum_adj = sum + {{tfds_pkg::TEMP_W{1'b0}}, sum[tfds_pkg::TEMP_W]};
	assign avg     = sum_adj[tfds_pkg::TEMP_W:1];

	assign go_up   = (avg >= tfds_pkg::up_at(airflow_front_to_back, level)) &&
		(level != tfds_pkg::LVL_100);
	assign go_down = (avg <= tfds_pkg::down_at(airflow_front_to_back, level)) &&
		(level != tfds_pkg::LVL_40);

	always_comb begin
		step.fault = fault;
		if (fault) begin
			step.level = tfds_pkg::LVL_100;
			step.write = 1'b1;
		end else if (go_up) begin
			step.level = level + 2'd1;
			step.write = 1'b1;
		end else if (go_down) begin
			step.level = level - 2'd1;
			step.write = 1'b1;
		end else begin
			step.level = level;
			step.write = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> rtl/thermal_fan_duty_stepper.sv
// Stepped fan duty controller with hysteresis.
// Channel tick (sink): one request per management tick, carrying two
//   temperatures in millidegrees, present and failed fan masks and the
//   airflow direction bit.
// Channel duty (source): one result per request, duty_percent (40, 65, 80
//   or 100) and write_duty, set when a duty setting is issued.
// A request is registered on acceptance, decided against the duty level and
// lands in the result register when that register is empty or being taken.
// Throughput is one request per cycle while the receiver takes results; the
// level register is the only state carried between requests and updates as a
// request moves to the result register.
// When the receiver stalls, the result register holds and one more request
// is still taken into the input register; tick.ready drops only when both
// are full.
// Reset clears both valid flags and sets the level to 40 percent.
`default_nettype none
module thermal_fan_duty_stepper (
	input  wire logic clk,
	input  wire logic arst_n,
	tfds_in_if.sink   tick,
	tfds_out_if.source duty
);

	logic                               valid_s1;
	logic signed [tfds_pkg::TEMP_W-1:0] temp_first_s1;
	logic signed [tfds_pkg::TEMP_W-1:0] temp_second_s1;
	logic [tfds_pkg::MASK_W-1:0]        present_s1;
	logic [tfds_pkg::MASK_W-1:0]        failed_s1;
	logic                               f2b_s1;

	logic                               valid_s2;
	logic [tfds_pkg::DUTY_W-1:0]        duty_s2;
	logic                               write_s2;

	logic [tfds_pkg::LEVEL_W-1:0]       level_q;
	tfds_pkg::step_t                    step;
	logic                               advance;
	logic                               take;

	assign advance    = valid_s1 && (!valid_s2 || duty.ready);
	assign take       = tick.valid && tick.ready;
	assign tick.ready = !valid_s1 || advance;

	tfds_step u_step (
		.level                 (level_q),
		.temp_first            (temp_first_s1),
		.temp_second           (temp_second_s1),
		.fan_present_mask      (present_s1),
		.fan_failed_mask       (failed_s1),
		.airflow_front_to_back (f2b_s1),
		.step                  (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			level_q  <= tfds_pkg::LVL_40;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				level_q  <= step.level;
			end else if (duty.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			temp_first_s1  <= tick.temp_first;
			temp_second_s1 <= tick.temp_second;
			present_s1     <= tick.fan_present_mask;
			failed_s1      <= tick.fan_failed_mask;
			f2b_s1         <= tick.airflow_front_to_back;
		end
		if (advance) begin
			duty_s2  <= tfds_pkg::duty_of(step.level);
			write_s2 <= step.write;
		end
	end

	assign duty.valid        = valid_s2;
	assign duty.duty_percent = duty_s2;
	assign duty.write_duty   = write_s2;

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(level_q))
		else $error("level moved without a request advancing");

	a_fault_top: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step.fault |=> level_q == tfds_pkg::LVL_100 && write_s2)
		else $error("fan fault did not force full duty");

	a_no_write_same: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !step.write |=> level_q == $past(level_q))
		else $error("level changed without a write");

	a_duty_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> duty_s2 == tfds_pkg::duty_of(level_q))
		else $error("result duty disagrees with level");

endmodule
`default_nettype wire

>>> test/fan_duty_checker.sv
`default_nettype none
module fan_duty_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tfds_in_if        tick,
	tfds_out_if       duty,
	output int        failures,
	output int        pending
);

	typedef struct packed {
		logic [tfds_pkg::DUTY_W-1:0] duty_percent;
		logic                        write_duty;
	} duty_setting_t;

	logic [tfds_pkg::LEVEL_W-1:0] level;
	logic [tfds_pkg::LEVEL_W-1:0] next_level;
	int                           mean_temp;
	duty_setting_t                want;
	duty_setting_t                settings_due[$];

	function automatic int rise_point(input logic f2b,
		input logic [tfds_pkg::LEVEL_W-1:0] lvl);
		int t;
		case (lvl)
			tfds_pkg::LVL_40:  t = f2b ? 47950 : 40850;
			tfds_pkg::LVL_65:  t = f2b ? 49650 : 44850;
			tfds_pkg::LVL_80:  t = f2b ? 54050 : 47400;
			default:           t = 0;
		endcase
		return t;
	endfunction

	function automatic int fall_point(input logic f2b,
		input logic [tfds_pkg::LEVEL_W-1:0] lvl);
		int t;
		case (lvl)
			tfds_pkg::LVL_65:  t = f2b ? 42050 : 35400;
			tfds_pkg::LVL_80:  t = f2b ? 47050 : 40400;
			tfds_pkg::LVL_100: t = f2b ? 52050 : 45400;
			default:           t = 0;
		endcase
		return t;
	endfunction

	function automatic logic [tfds_pkg::DUTY_W-1:0] percent_of(
		input logic [tfds_pkg::LEVEL_W-1:0] lvl);
		logic [tfds_pkg::DUTY_W-1:0] d;
		case (lvl)
			tfds_pkg::LVL_40:  d = tfds_pkg::DUTY_40;
			tfds_pkg::LVL_65:  d = tfds_pkg::DUTY_65;
			tfds_pkg::LVL_80:  d = tfds_pkg::DUTY_80;
			default:           d = tfds_pkg::DUTY_100;
		endcase
		return d;
	endfunction

	task automatic report_fault(input string msg);
		$display("%0t: %s", $time, msg);
		failures++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			level = tfds_pkg::LVL_40;
			failures = 0;
			settings_due.delete();
		end else begin
			if (tick.valid && tick.ready) begin
				next_level = level;
				if ((tick.fan_present_mask & tfds_pkg::MON_MASK) != tfds_pkg::MON_MASK ||
					(tick.fan_failed_mask & tfds_pkg::MON_MASK) != '0) begin
					next_level = tfds_pkg::LVL_100;
					want.write_duty = 1'b1;
				end else begin
					mean_temp = (int'(tick.temp_first) + int'(tick.temp_second)) / 2;
					if (level != tfds_pkg::LVL_100 &&
						mean_temp >= rise_point(tick.airflow_front_to_back, level))
						next_level = level + 1'b1;
					else if (level != tfds_pkg::LVL_40 &&
						mean_temp <= fall_point(tick.airflow_front_to_back, level))
						next_level = level - 1'b1;
					want.write_duty = next_level != level;
				end
				level = next_level;
				want.duty_percent = percent_of(level);
				settings_due.push_back(want);
			end
			if (duty.valid && duty.ready) begin
				if (settings_due.size() == 0) begin
					report_fault($sformatf("duty result %0d/%0d with no request outstanding",
						duty.duty_percent, duty.write_duty));
				end else begin
					want = settings_due.pop_front();
					if (duty.duty_percent !== want.duty_percent)
						report_fault($sformatf("duty_percent is %0d, expected %0d",
							duty.duty_percent, want.duty_percent));
					if (duty.write_duty !== want.write_duty)
						report_fault($sformatf("write_duty is %0d, expected %0d",
							duty.write_duty, want.write_duty));
				end
			end
		end
		pending = settings_due.size();
	end

endmodule
`default_nettype wire

>>> test/thermal_fan_duty_stepper_test.sv
`default_nettype none
module thermal_fan_duty_stepper_test;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	bit   src_idle;
	bit   sink_idle;
	bit   long_hold;

	tfds_in_if  tick_ch();
	tfds_out_if duty_ch();

	thermal_fan_duty_stepper DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.duty  (duty_ch)
	);

	fan_duty_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.duty    (duty_ch),
		.failures(failures),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		duty_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = 60;
			end else if (hold_left == 0 && sink_idle && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(1, 15);
			end
			if (hold_left > 0) begin
				duty_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				duty_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_tick(input int t1, input int t2,
		input logic [tfds_pkg::MASK_W-1:0] present,
		input logic [tfds_pkg::MASK_W-1:0] failed, input logic f2b);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		tick_ch.valid                 <= 1'b1;
		tick_ch.temp_first            <= tfds_pkg::temp_t'(t1);
		tick_ch.temp_second           <= tfds_pkg::temp_t'(t2);
		tick_ch.fan_present_mask      <= present;
		tick_ch.fan_failed_mask       <= failed;
		tick_ch.airflow_front_to_back <= f2b;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		int                          mid;
		int                          t1;
		int                          t2;
		int                          pick;
		logic [tfds_pkg::MASK_W-1:0] present;
		logic [tfds_pkg::MASK_W-1:0] failed;

		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.temp_first = '0;
		tick_ch.temp_second = '0;
		tick_ch.fan_present_mask = '0;
		tick_ch.fan_failed_mask = '0;
		tick_ch.airflow_front_to_back = 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		long_hold = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// climb through every level, then fall, both airflow directions
		send_tick(0, 0, 5'h1f, 5'h00, 1'b0);
		send_tick(40850, 40849, 5'h1f, 5'h00, 1'b0);
		send_tick(40850, 40850, 5'h1f, 5'h00, 1'b0);
		send_tick(44850, 44850, 5'h1f, 5'h00, 1'b0);
		send_tick(47400, 47401, 5'h1f, 5'h00, 1'b0);
		send_tick(131071, 131071, 5'h1f, 5'h00, 1'b0);
		send_tick(45401, 45401, 5'h1f, 5'h00, 1'b0);
		send_tick(45400, 45401, 5'h1f, 5'h00, 1'b0);
		send_tick(-131072, -131072, 5'h1f, 5'h00, 1'b1);
		send_tick(-131072, -131071, 5'h1f, 5'h00, 1'b1);
		send_tick(-131072, -131072, 5'h1f, 5'h00, 1'b1);
		send_tick(47950, 47949, 5'h1f, 5'h00, 1'b1);
		send_tick(47950, 47950, 5'h1f, 5'h00, 1'b1);
		send_tick(49650, 49650, 5'h1f, 5'h00, 1'b1);
		send_tick(54050, 54050, 5'h1f, 5'h00, 1'b1);
		send_tick(52050, 52051, 5'h1f, 5'h00, 1'b1);
		// fan faults, repeated at full duty, then falling back with mixed-sign averages
		send_tick(0, 0, 5'h1e, 5'h00, 1'b1);
		send_tick(0, 0, 5'h1f, 5'h10, 1'b1);
		send_tick(0, 0, 5'h0f, 5'h00, 1'b0);
		send_tick(0, 0, 5'h1f, 5'h01, 1'b0);
		send_tick(-1, 0, 5'h1f, 5'h1f, 1'b1);
		send_tick(42050, 42050, 5'h1f, 5'h00, 1'b1);
		send_tick(-1, 0, 5'h1f, 5'h00, 1'b1);
		send_tick(125000, -55000, 5'h1f, 5'h00, 1'b0);
		send_tick(-55000, 125000, 5'h1f, 5'h00, 1'b1);

		for (int n = 0; n < 750; n++) begin
			if (n == 0) begin
				src_idle = 1'b0;
				long_hold = 1'b1;
			end else if (n == 100) begin
				src_idle = 1'b1;
			end else if (n == 650) begin
				src_idle = 1'b0;
				sink_idle = 1'b0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				present = tfds_pkg::MASK_W'($urandom);
				failed = tfds_pkg::MASK_W'($urandom);
			end else if (pick < 10) begin
				present = '1;
				failed = tfds_pkg::MASK_W'($urandom_range(1, 31));
			end else begin
				present = '1;
				failed = '0;
			end
			if (pick >= 92) begin
				t1 = $urandom;
				t2 = $urandom;
			end else begin
				mid = $urandom_range(33000, 56000);
				t1 = mid + int'($urandom_range(0, 40000)) - 20000;
				t2 = 2 * mid - t1 + int'($urandom_range(0, 1));
			end
			send_tick(t1, t2, present, failed, 1'($urandom));
		end

		tick_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/tfds_pkg.sv
rtl/tfds_if.sv
rtl/tfds_step.sv
rtl/thermal_fan_duty_stepper.sv
test/fan_duty_checker.sv
test/thermal_fan_duty_stepper_test.sv
